[design/sstok_pkg.sv]
// shared types, codes and helper functions for the source tokenizer
package sstok_pkg;

	localparam logic [2:0] K_COMMENT = 3'd0;
	localparam logic [2:0] K_STRING  = 3'd1;
	localparam logic [2:0] K_LONG    = 3'd2;
	localparam logic [2:0] K_NUMBER  = 3'd3;
	localparam logic [2:0] K_WORD    = 3'd4;
	localparam logic [2:0] K_SYMBOL  = 3'd5;
	localparam logic [2:0] K_END     = 3'd6;

	typedef struct packed {
		logic load;
		logic step;
		logic flush;
	} sstok_cmd_t;

	typedef struct packed {
		logic done;
		logic out_free;
		logic pend_v;
	} sstok_stat_t;

	function automatic logic [15:0] sat16(input logic [15:0] a, input logic [15:0] n);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, n};
		return s[16] ? 16'hFFFF : s[15:0];
	endfunction

	function automatic logic [23:0] sat24(input logic [23:0] a, input logic [23:0] n);
		logic [24:0] s;
		s = {1'b0, a} + {1'b0, n};
		return s[24] ? 24'hFFFFFF : s[23:0];
	endfunction

endpackage

[design/script_source_tokenizer_top.sv]
// top level of the streaming script source tokenizer
// Takes one source byte (or an end mark) per input transfer and sends out the tokens it
// closes, each with kind, start line, column, offset and length; last_of_run marks the
// final token of a transfer. An item is loaded in the wait state, then the lexer takes one
// step for every byte it feeds through: the byte itself, once more each time it closes a
// token and is fed again, and any held lookahead bytes replayed (at most MAX_LEVEL); the
// flush state then hands over the last result. The one-deep result register keeps a token
// until the next one or the end of the item shows whether it is the last; the lexer steps
// only while the output register is empty or being taken, so a stalled output holds the
// item.
module script_source_tokenizer_top
	import sstok_pkg::*;
#(
	parameter int MAX_LEVEL = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic [7:0]  src_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  token_kind,
	output logic [15:0] start_line,
	output logic [15:0] start_column,
	output logic [23:0] start_offset,
	output logic [23:0] token_length,
	output logic        level_overflow,
	output logic        last_of_run
);

	sstok_cmd_t  cmd;
	sstok_stat_t stat;

	sstok_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	sstok_dp #(
		.MAX_LEVEL (MAX_LEVEL)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.action         (action),
		.src_byte       (src_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.token_kind     (token_kind),
		.start_line     (start_line),
		.start_column   (start_column),
		.start_offset   (start_offset),
		.token_length   (token_length),
		.level_overflow (level_overflow),
		.last_of_run    (last_of_run)
	);

endmodule

[design/sstok_ctrl.sv]
// sequencing controller: item intake, byte stepping and result flush
module sstok_ctrl
	import sstok_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  sstok_stat_t stat,
	output sstok_cmd_t  cmd
);

	typedef enum logic [1:0] {S_WAIT, S_RUN, S_FLUSH} state_t;

	state_t state_q;

	assign in_stall  = (state_q != S_WAIT);
	assign cmd.load  = (state_q == S_WAIT) && in_valid;
	assign cmd.step  = (state_q == S_RUN) && stat.out_free;
	assign cmd.flush = (state_q == S_FLUSH) && (stat.out_free || !stat.pend_v);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_WAIT;
		end else begin
			unique case (state_q)
				S_WAIT: begin
					if (in_valid) state_q <= S_RUN;
				end
				S_RUN: begin
					if (cmd.step && stat.done) state_q <= S_FLUSH;
				end
				S_FLUSH: begin
					if (cmd.flush) state_q <= S_WAIT;
				end
				default: state_q <= S_WAIT;
			endcase
		end
	end

endmodule

[design/sstok_dp.sv]
// tokenizer datapath: lexer state, positions, held lookahead and result registers
module sstok_dp
	import sstok_pkg::*;
#(
	parameter int MAX_LEVEL = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  sstok_cmd_t  cmd,
	output sstok_stat_t stat,
	input  logic        action,
	input  logic [7:0]  src_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  token_kind,
	output logic [15:0] start_line,
	output logic [15:0] start_column,
	output logic [23:0] start_offset,
	output logic [23:0] token_length,
	output logic        level_overflow,
	output logic        last_of_run
);

	localparam int HELD_CAP = MAX_LEVEL + 2;
	localparam int LW = $clog2(MAX_LEVEL + 2);
	localparam int HW = $clog2(HELD_CAP + 1);
	localparam int IW = $clog2(HELD_CAP);

	typedef enum logic [4:0] {
		M_IDLE, M_OP1, M_DOT, M_DOTDOT, M_CMT_START, M_CMT_BR, M_LINE_CMT,
		M_LONGBODY, M_STR, M_BR_OPEN, M_NUM_ZERO, M_NUM_INT, M_NUM_DOT,
		M_NUM_FRAC, M_NUM_E, M_NUM_ES, M_NUM_EXP, M_HEX, M_HEX_P, M_HEX_EXP,
		M_BIN, M_WORD
	} mode_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] line;
		logic [15:0] col;
		logic [23:0] off;
		logic [23:0] len;
		logic        flag;
	} res_t;

	function automatic logic is_c(input logic [8:0] c, input logic [7:0] x);
		return c == {1'b0, x};
	endfunction

	function automatic logic is_dig(input logic [8:0] c);
		return !c[8] && c[7:0] >= "0" && c[7:0] <= "9";
	endfunction

	function automatic logic is_alp(input logic [8:0] c);
		return !c[8] && ((c[7:0] >= "a" && c[7:0] <= "z") ||
			(c[7:0] >= "A" && c[7:0] <= "Z") || c[7:0] == "_");
	endfunction

	function automatic logic is_hexd(input logic [8:0] c);
		return is_dig(c) || (!c[8] && ((c[7:0] >= "a" && c[7:0] <= "f") ||
			(c[7:0] >= "A" && c[7:0] <= "F")));
	endfunction

	function automatic logic pair_ok(input logic [7:0] a, input logic [8:0] b);
		logic r;
		r = 1'b0;
		case (a)
			":":      r = is_c(b, ":");
			"=", "~": r = is_c(b, "=");
			"<":      r = is_c(b, "=") || is_c(b, "<");
			">":      r = is_c(b, "=") || is_c(b, ">");
			"/":      r = is_c(b, "/");
			default:  r = 1'b0;
		endcase
		return r;
	endfunction

	// lexer state
	mode_t          mode_q;
	logic [15:0]    cur_line_q, cur_col_q, tok_line_q, tok_col_q;
	logic [23:0]    cur_off_q, tok_off_q, tok_len_q;
	logic           tok_flag_q, qsingle_q, esc_q, body_long_q;
	logic [LW-1:0]  level_q, close_q;
	logic [7:0]     op_first_q;
	logic [7:0]     held_q [HELD_CAP];
	logic [HW-1:0]  held_cnt_q;
	// current byte and replay pointer
	logic [7:0]     byte_q;
	logic           end_q;
	logic           rp_act_q;
	logic [IW-1:0]  rp_i_q;
	logic [HW-1:0]  rp_n_q;
	// result staging
	res_t           pend_q, out_q;
	logic           pend_v_q, out_v_q, out_last_q;

	// step outputs
	logic [8:0]     c9;
	mode_t          mode_n;
	logic           adv, take, emit, emit_end, consume, replay, start, hold_en, clr, set_flag;
	logic           do_int, do_frac, do_line;
	logic [2:0]     kind;
	logic [LW-1:0]  level_n, close_n;
	logic           qsingle_n, esc_n, body_long_n;
	logic [7:0]     op_first_n, qch;
	logic [HW-1:0]  hc;
	logic           hold_we;
	logic [IW-1:0]  hold_idx;
	logic [HW:0]    n_adv;
	logic           lf;
	logic [15:0]    cur_line_n, cur_col_n, tok_line_n, tok_col_n;
	logic [23:0]    cur_off_n, tok_off_n, tok_len_n;
	logic           tok_flag_n;
	res_t           res_n;
	logic           done;

	always_comb begin
		c9 = rp_act_q ? {1'b0, held_q[rp_i_q]} : {end_q, byte_q};
		mode_n = mode_q;
		adv = 1'b0; take = 1'b0; emit = 1'b0; emit_end = 1'b0; consume = 1'b1;
		replay = 1'b0; start = 1'b0; hold_en = 1'b0; clr = 1'b0; set_flag = 1'b0;
		do_int = 1'b0; do_frac = 1'b0; do_line = 1'b0;
		kind = K_SYMBOL;
		level_n = level_q; close_n = close_q;
		qsingle_n = qsingle_q; esc_n = esc_q; body_long_n = body_long_q;
		op_first_n = op_first_q;
		qch = qsingle_q ? 8'h27 : 8'h22;

		unique case (mode_q)
			M_IDLE: begin
				if (c9[8]) begin
					emit = 1'b1; emit_end = 1'b1; kind = K_END; clr = 1'b1;
				end else if (is_c(c9, " ") || is_c(c9, 8'h09) || is_c(c9, 8'h0D) ||
						is_c(c9, 8'h0A)) begin
					adv = 1'b1;
				end else begin
					start = 1'b1; adv = 1'b1;
					if (is_c(c9, "-") || is_c(c9, ":") || is_c(c9, "=") || is_c(c9, "~") ||
							is_c(c9, "<") || is_c(c9, ">") || is_c(c9, "/")) begin
						op_first_n = c9[7:0]; mode_n = M_OP1;
					end else if (is_c(c9, 8'h22) || is_c(c9, 8'h27)) begin
						qsingle_n = is_c(c9, 8'h27); esc_n = 1'b0; mode_n = M_STR;
					end else if (is_c(c9, "[")) begin
						level_n = '0; mode_n = M_BR_OPEN;
					end else if (is_c(c9, "0")) begin
						mode_n = M_NUM_ZERO;
					end else if (is_dig(c9)) begin
						mode_n = M_NUM_INT;
					end else if (is_c(c9, ".")) begin
						mode_n = M_DOT;
					end else if (is_alp(c9)) begin
						mode_n = M_WORD;
					end else begin
						emit = 1'b1;
					end
				end
			end
			M_OP1: begin
				if (op_first_q == "-" && is_c(c9, "-")) begin
					adv = 1'b1; mode_n = M_CMT_START;
				end else if (pair_ok(op_first_q, c9)) begin
					adv = 1'b1; emit = 1'b1;
				end else begin
					emit = 1'b1; consume = 1'b0;
				end
			end
			M_DOT: begin
				if (is_dig(c9)) begin
					adv = 1'b1; mode_n = M_NUM_FRAC;
				end else if (is_c(c9, ".")) begin
					adv = 1'b1; mode_n = M_DOTDOT;
				end else begin
					emit = 1'b1; consume = 1'b0;
				end
			end
			M_DOTDOT: begin
				if (is_c(c9, ".")) begin
					adv = 1'b1; emit = 1'b1;
				end else begin
					emit = 1'b1; consume = 1'b0;
				end
			end
			M_CMT_START: begin
				if (is_c(c9, "[")) begin
					adv = 1'b1; level_n = '0; mode_n = M_CMT_BR;
				end else begin
					do_line = 1'b1;
				end
			end
			M_CMT_BR: begin
				if (is_c(c9, "=")) begin
					adv = 1'b1;
					if (level_q >= LW'(MAX_LEVEL)) begin
						set_flag = 1'b1; mode_n = M_LINE_CMT;
					end else begin
						level_n = level_q + 1'b1;
					end
				end else if (is_c(c9, "[")) begin
					adv = 1'b1; close_n = '0; body_long_n = 1'b0; mode_n = M_LONGBODY;
				end else begin
					do_line = 1'b1;
				end
			end
			M_LINE_CMT: do_line = 1'b1;
			M_LONGBODY: begin
				kind = body_long_q ? K_LONG : K_COMMENT;
				if (c9[8]) begin
					emit = 1'b1; consume = 1'b0;
				end else begin
					adv = 1'b1;
					if (close_q == '0) begin
						close_n = LW'(is_c(c9, "]"));
					end else if (close_q <= level_q) begin
						close_n = is_c(c9, "=") ? close_q + 1'b1 : LW'(is_c(c9, "]"));
					end else if (is_c(c9, "]")) begin
						emit = 1'b1;
					end else begin
						close_n = '0;
					end
				end
			end
			M_STR: begin
				kind = K_STRING;
				if (c9[8]) begin
					emit = 1'b1; consume = 1'b0;
				end else begin
					adv = 1'b1;
					if (esc_q) esc_n = 1'b0;
					else if (is_c(c9, 8'h5C)) esc_n = 1'b1;
					else if (is_c(c9, qch)) emit = 1'b1;
				end
			end
			M_BR_OPEN: begin
				if (is_c(c9, "=")) begin
					if (level_q >= LW'(MAX_LEVEL)) begin
						set_flag = 1'b1; emit = 1'b1; replay = 1'b1; consume = 1'b0;
					end else begin
						hold_en = 1'b1; level_n = level_q + 1'b1;
					end
				end else if (is_c(c9, "[")) begin
					take = 1'b1; adv = 1'b1; close_n = '0; body_long_n = 1'b1;
					mode_n = M_LONGBODY;
				end else begin
					emit = 1'b1; replay = 1'b1; consume = 1'b0;
				end
			end
			M_NUM_ZERO: begin
				if (is_c(c9, "x") || is_c(c9, "X")) begin
					adv = 1'b1; mode_n = M_HEX;
				end else if (is_c(c9, "b") || is_c(c9, "B")) begin
					adv = 1'b1; mode_n = M_BIN;
				end else begin
					do_int = 1'b1;
				end
			end
			M_NUM_INT:  do_int = 1'b1;
			M_NUM_DOT: begin
				kind = K_NUMBER;
				if (is_c(c9, ".")) begin
					emit = 1'b1; replay = 1'b1; consume = 1'b0;
				end else begin
					take = 1'b1; do_frac = 1'b1;
				end
			end
			M_NUM_FRAC: do_frac = 1'b1;
			M_NUM_E, M_NUM_ES: begin
				kind = K_NUMBER;
				if (mode_q == M_NUM_E && (is_c(c9, "+") || is_c(c9, "-"))) begin
					hold_en = 1'b1; mode_n = M_NUM_ES;
				end else if (is_dig(c9)) begin
					take = 1'b1; adv = 1'b1; mode_n = M_NUM_EXP;
				end else begin
					emit = 1'b1; replay = 1'b1; consume = 1'b0;
				end
			end
			M_NUM_EXP, M_HEX_EXP: begin
				kind = K_NUMBER;
				if (is_dig(c9)) adv = 1'b1;
				else begin
					emit = 1'b1; consume = 1'b0;
				end
			end
			M_HEX: begin
				kind = K_NUMBER;
				if (is_hexd(c9) || is_c(c9, ".")) begin
					adv = 1'b1;
				end else if (is_c(c9, "p") || is_c(c9, "P")) begin
					adv = 1'b1; mode_n = M_HEX_P;
				end else begin
					emit = 1'b1; consume = 1'b0;
				end
			end
			M_HEX_P: begin
				kind = K_NUMBER;
				if (is_c(c9, "+") || is_c(c9, "-") || is_dig(c9)) begin
					adv = 1'b1; mode_n = M_HEX_EXP;
				end else begin
					emit = 1'b1; consume = 1'b0;
				end
			end
			M_BIN: begin
				kind = K_NUMBER;
				if (is_c(c9, "0") || is_c(c9, "1")) adv = 1'b1;
				else begin
					emit = 1'b1; consume = 1'b0;
				end
			end
			M_WORD: begin
				kind = K_WORD;
				if (is_alp(c9) || is_dig(c9)) adv = 1'b1;
				else begin
					emit = 1'b1; consume = 1'b0;
				end
			end
			default: begin
				mode_n = M_IDLE; consume = 1'b0;
			end
		endcase

		// shared tails of the number and line comment rules
		if (do_int) begin
			mode_n = M_NUM_INT;
			if (is_c(c9, ".")) begin
				hold_en = 1'b1; mode_n = M_NUM_DOT;
			end else if (is_dig(c9)) begin
				adv = 1'b1;
			end else begin
				do_frac = 1'b1;
			end
		end
		if (do_frac) begin
			mode_n = M_NUM_FRAC;
			kind = K_NUMBER;
			if (is_dig(c9)) begin
				adv = 1'b1;
			end else if (is_c(c9, "e") || is_c(c9, "E")) begin
				hold_en = 1'b1; mode_n = M_NUM_E;
			end else begin
				emit = 1'b1; consume = 1'b0;
			end
		end
		if (do_line) begin
			mode_n = M_LINE_CMT;
			kind = K_COMMENT;
			if (c9[8] || is_c(c9, 8'h0A)) begin
				emit = 1'b1; consume = 1'b0;
			end else begin
				adv = 1'b1;
			end
		end
		if (emit) mode_n = M_IDLE;

		// held lookahead bookkeeping
		hc = held_cnt_q;
		if (start || take) hc = '0;
		hold_we = hold_en && (hc < HW'(HELD_CAP));
		hold_idx = hc[IW-1:0];
		if (hold_we) hc = hc + 1'b1;
		if (replay) hc = '0;

		// positions
		n_adv = (take ? {1'b0, held_cnt_q} : '0) + (HW+1)'(adv);
		lf = adv && is_c(c9, 8'h0A);
		cur_line_n = (lf && cur_line_q != 16'hFFFF) ? cur_line_q + 16'd1 : cur_line_q;
		cur_col_n  = lf ? 16'd1 : sat16(cur_col_q, 16'(n_adv));
		cur_off_n  = sat24(cur_off_q, 24'(n_adv));
		tok_line_n = start ? cur_line_q : tok_line_q;
		tok_col_n  = start ? cur_col_q : tok_col_q;
		tok_off_n  = start ? cur_off_q : tok_off_q;
		tok_len_n  = sat24(start ? 24'd0 : tok_len_q, 24'(n_adv));
		tok_flag_n = (start ? 1'b0 : tok_flag_q) | set_flag;

		if (emit_end) begin
			res_n = '{kind: K_END, line: cur_line_q, col: cur_col_q, off: cur_off_q,
				len: 24'd0, flag: 1'b0};
		end else begin
			res_n = '{kind: kind, line: tok_line_n, col: tok_col_n, off: tok_off_n,
				len: tok_len_n, flag: tok_flag_n};
		end

		done = consume && !rp_act_q;
	end

	assign stat.done     = done;
	assign stat.out_free = !out_v_q || !out_stall;
	assign stat.pend_v   = pend_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= M_IDLE;
			cur_line_q  <= 16'd1;
			cur_col_q   <= 16'd1;
			cur_off_q   <= '0;
			tok_line_q  <= 16'd1;
			tok_col_q   <= 16'd1;
			tok_off_q   <= '0;
			tok_len_q   <= '0;
			tok_flag_q  <= 1'b0;
			level_q     <= '0;
			close_q     <= '0;
			qsingle_q   <= 1'b0;
			esc_q       <= 1'b0;
			body_long_q <= 1'b0;
			op_first_q  <= '0;
			held_cnt_q  <= '0;
			rp_act_q    <= 1'b0;
			rp_i_q      <= '0;
			rp_n_q      <= '0;
			pend_v_q    <= 1'b0;
			out_v_q     <= 1'b0;
		end else begin
			if (out_v_q && !out_stall) out_v_q <= 1'b0;
			if (cmd.load) begin
				rp_act_q <= 1'b0;
			end
			if (cmd.step) begin
				if (emit) begin
					pend_v_q <= 1'b1;
					if (pend_v_q) out_v_q <= 1'b1;
				end
				if (rp_act_q && consume) begin
					if (HW'(rp_i_q) + 1'b1 == rp_n_q) rp_act_q <= 1'b0;
					else rp_i_q <= rp_i_q + 1'b1;
				end
				if (replay) begin
					rp_act_q <= (held_cnt_q != '0);
					rp_i_q   <= '0;
					rp_n_q   <= held_cnt_q;
				end
				if (clr) begin
					mode_q      <= M_IDLE;
					cur_line_q  <= 16'd1;
					cur_col_q   <= 16'd1;
					cur_off_q   <= '0;
					tok_line_q  <= 16'd1;
					tok_col_q   <= 16'd1;
					tok_off_q   <= '0;
					tok_len_q   <= '0;
					tok_flag_q  <= 1'b0;
					level_q     <= '0;
					close_q     <= '0;
					qsingle_q   <= 1'b0;
					esc_q       <= 1'b0;
					body_long_q <= 1'b0;
					op_first_q  <= '0;
					held_cnt_q  <= '0;
				end else begin
					mode_q      <= mode_n;
					cur_line_q  <= cur_line_n;
					cur_col_q   <= cur_col_n;
					cur_off_q   <= cur_off_n;
					tok_line_q  <= tok_line_n;
					tok_col_q   <= tok_col_n;
					tok_off_q   <= tok_off_n;
					tok_len_q   <= tok_len_n;
					tok_flag_q  <= tok_flag_n;
					level_q     <= level_n;
					close_q     <= close_n;
					qsingle_q   <= qsingle_n;
					esc_q       <= esc_n;
					body_long_q <= body_long_n;
					op_first_q  <= op_first_n;
					held_cnt_q  <= hc;
				end
			end
			if (cmd.flush && pend_v_q) begin
				pend_v_q <= 1'b0;
				out_v_q  <= 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			byte_q <= src_byte;
			end_q  <= action;
		end
		if (cmd.step && hold_we) held_q[hold_idx] <= c9[7:0];
		if (cmd.step && emit) begin
			pend_q <= res_n;
			if (pend_v_q) begin
				out_q      <= pend_q;
				out_last_q <= 1'b0;
			end
		end
		if (cmd.flush && pend_v_q) begin
			out_q      <= pend_q;
			out_last_q <= 1'b1;
		end
	end

	assign out_valid      = out_v_q;
	assign token_kind     = out_q.kind;
	assign start_line     = out_q.line;
	assign start_column   = out_q.col;
	assign start_offset   = out_q.off;
	assign token_length   = out_q.len;
	assign level_overflow = out_q.flag;
	assign last_of_run    = out_last_q;

endmodule

[test/tb_script_source_tokenizer_top.sv]
// self-checking testbench for the script source tokenizer: lexer predictor, random source text
module tb_script_source_tokenizer_top;
	import sstok_pkg::*;

	localparam int LVL_MAX = 8;
	localparam int END_CODE = 256;
	localparam int OFF_TOP = 24'hFFFFFF;
	localparam bit ACT_BYTE = 1'b0;
	localparam bit ACT_END = 1'b1;

	typedef enum {
		L_IDLE, L_OP1, L_DOT, L_DOTDOT, L_CMT_START, L_CMT_BR, L_LINE_CMT, L_LONGBODY,
		L_STR, L_BR_OPEN, L_NUM_ZERO, L_NUM_INT, L_NUM_DOT, L_NUM_FRAC, L_NUM_E,
		L_NUM_ES, L_NUM_EXP, L_HEX, L_HEX_P, L_HEX_EXP, L_BIN, L_WORD
	} lex_mode_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] line;
		logic [15:0] col;
		logic [23:0] off;
		logic [23:0] len;
		logic        ovf;
		logic        last;
	} token_t;

	typedef struct packed {
		bit       act;
		bit [7:0] b;
	} src_item_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_stall;
	logic        action = 0;
	logic [7:0]  src_byte = 0;
	logic        out_valid;
	logic        out_stall = 0;
	logic [2:0]  token_kind;
	logic [15:0] start_line;
	logic [15:0] start_column;
	logic [23:0] start_offset;
	logic [23:0] token_length;
	logic        level_overflow;
	logic        last_of_run;

	script_source_tokenizer_top #(.MAX_LEVEL(LVL_MAX)) dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.action(action), .src_byte(src_byte), .out_valid(out_valid), .out_stall(out_stall),
		.token_kind(token_kind), .start_line(start_line), .start_column(start_column),
		.start_offset(start_offset), .token_length(token_length),
		.level_overflow(level_overflow), .last_of_run(last_of_run)
	);

	src_item_t source_q[$];
	token_t    expected_tokens[$];
	token_t    step_tokens[$];
	int        lex_work[$];
	int        errors = 0;

	lex_mode_t mode;
	int unsigned cur_line, cur_col, cur_off, tok_line, tok_col, tok_off, tok_len, tok_flag;
	int unsigned br_level, close_prog, quote_single, esc_pend, held_n, op_first, body_kind;
	int unsigned held[LVL_MAX + 2];

	function automatic void lexer_clear();
		mode = L_IDLE;
		cur_line = 1; cur_col = 1; cur_off = 0;
		tok_line = 1; tok_col = 1; tok_off = 0; tok_len = 0; tok_flag = 0;
		br_level = 0; close_prog = 0; quote_single = 0; esc_pend = 0;
		held_n = 0; op_first = 0; body_kind = K_COMMENT;
	endfunction

	function automatic bit is_dig(int c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_alpha(int c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic bit is_hexd(int c);
		return is_dig(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
	endfunction

	function automatic void step_pos(int c);
		if (c == 10) begin
			if (cur_line < 65535) cur_line++;
			cur_col = 1;
		end else if (cur_col < 65535) cur_col++;
		if (cur_off < OFF_TOP) cur_off++;
		if (tok_len < OFF_TOP) tok_len++;
	endfunction

	function automatic void put_token(int unsigned k, int unsigned ln, int unsigned cl,
			int unsigned of, int unsigned le, int unsigned fl);
		token_t t;
		if (step_tokens.size() < 12) begin
			t.kind = 3'(k); t.line = 16'(ln); t.col = 16'(cl); t.off = 24'(of);
			t.len = 24'(le); t.ovf = fl[0];
			t.last = 1'b0;
			step_tokens.insert(step_tokens.size(), t);
		end
	endfunction

	function automatic void close_token(int unsigned k);
		put_token(k, tok_line, tok_col, tok_off, tok_len, tok_flag);
		mode = L_IDLE;
	endfunction

	function automatic void requeue(int c);
		lex_work.push_front(c);
	endfunction

	function automatic void replay_held(int c);
		requeue(c);
		while (held_n > 0) begin
			held_n--;
			requeue(held[held_n]);
		end
	endfunction

	function automatic void hold(int c);
		if (held_n < LVL_MAX + 2) begin
			held[held_n] = c;
			held_n++;
		end
	endfunction

	function automatic void take_held();
		for (int i = 0; i < held_n; i++) step_pos(held[i]);
		held_n = 0;
	endfunction

	function automatic bit pair_ok(int a, int b);
		case (a)
			":": return b == ":";
			"=", "~": return b == "=";
			"<": return b == "=" || b == "<";
			">": return b == "=" || b == ">";
			"/": return b == "/";
			default: return 0;
		endcase
	endfunction

	function automatic void start_token(int c);
		if (c == END_CODE) begin
			put_token(K_END, cur_line, cur_col, cur_off, 0, 0);
			lexer_clear();
			return;
		end
		if (c == " " || c == 9 || c == 13 || c == 10) begin
			step_pos(c);
			return;
		end
		tok_line = cur_line; tok_col = cur_col; tok_off = cur_off;
		tok_len = 0; tok_flag = 0; held_n = 0;
		step_pos(c);
		if (c == "-" || c == ":" || c == "=" || c == "~" || c == "<" || c == ">" || c == "/") begin
			op_first = c; mode = L_OP1;
		end else if (c == 34 || c == 39) begin
			quote_single = (c == 39); esc_pend = 0; mode = L_STR;
		end else if (c == "[") begin
			br_level = 0; mode = L_BR_OPEN;
		end else if (c == "0") mode = L_NUM_ZERO;
		else if (is_dig(c)) mode = L_NUM_INT;
		else if (c == ".") mode = L_DOT;
		else if (is_alpha(c)) mode = L_WORD;
		else close_token(K_SYMBOL);
	endfunction

	function automatic void line_comment(int c);
		mode = L_LINE_CMT;
		if (c == END_CODE || c == 10) begin
			close_token(K_COMMENT); requeue(c); return;
		end
		step_pos(c);
	endfunction

	function automatic void num_frac(int c);
		mode = L_NUM_FRAC;
		if (is_dig(c)) begin step_pos(c); return; end
		if (c == "e" || c == "E") begin hold(c); mode = L_NUM_E; return; end
		close_token(K_NUMBER); requeue(c);
	endfunction

	function automatic void num_int(int c);
		mode = L_NUM_INT;
		if (c == ".") begin hold(c); mode = L_NUM_DOT; return; end
		if (is_dig(c)) begin step_pos(c); return; end
		num_frac(c);
	endfunction

	function automatic void long_body(int c);
		if (c == END_CODE) begin close_token(body_kind); requeue(c); return; end
		step_pos(c);
		if (close_prog == 0) close_prog = (c == "]");
		else if (close_prog <= br_level) begin
			if (c == "=") close_prog++;
			else close_prog = (c == "]");
		end else if (c == "]") close_token(body_kind);
		else close_prog = 0;
	endfunction

	function automatic void lex_feed(int c);
		int q;
		case (mode)
			L_IDLE: start_token(c);
			L_OP1: begin
				if (op_first == "-" && c == "-") begin
					step_pos(c); mode = L_CMT_START;
				end else if (pair_ok(op_first, c)) begin
					step_pos(c); close_token(K_SYMBOL);
				end else begin
					close_token(K_SYMBOL); requeue(c);
				end
			end
			L_DOT: begin
				if (is_dig(c)) begin step_pos(c); mode = L_NUM_FRAC; end
				else if (c == ".") begin step_pos(c); mode = L_DOTDOT; end
				else begin close_token(K_SYMBOL); requeue(c); end
			end
			L_DOTDOT: begin
				if (c == ".") begin step_pos(c); close_token(K_SYMBOL); end
				else begin close_token(K_SYMBOL); requeue(c); end
			end
			L_CMT_START: begin
				if (c == "[") begin step_pos(c); br_level = 0; mode = L_CMT_BR; end
				else line_comment(c);
			end
			L_CMT_BR: begin
				if (c == "=") begin
					step_pos(c);
					if (br_level >= LVL_MAX) begin tok_flag = 1; mode = L_LINE_CMT; end
					else br_level++;
				end else if (c == "[") begin
					step_pos(c); close_prog = 0; body_kind = K_COMMENT; mode = L_LONGBODY;
				end else line_comment(c);
			end
			L_LINE_CMT: line_comment(c);
			L_LONGBODY: long_body(c);
			L_STR: begin
				if (c == END_CODE) begin
					close_token(K_STRING); requeue(c);
				end else begin
					step_pos(c);
					q = quote_single ? 39 : 34;
					if (esc_pend) esc_pend = 0;
					else if (c == 92) esc_pend = 1;
					else if (c == q) close_token(K_STRING);
				end
			end
			L_BR_OPEN: begin
				if (c == "=") begin
					if (br_level >= LVL_MAX) begin
						tok_flag = 1; close_token(K_SYMBOL); replay_held(c);
					end else begin
						hold(c); br_level++;
					end
				end else if (c == "[") begin
					take_held(); step_pos(c); close_prog = 0; body_kind = K_LONG;
					mode = L_LONGBODY;
				end else begin
					close_token(K_SYMBOL); replay_held(c);
				end
			end
			L_NUM_ZERO: begin
				if (c == "x" || c == "X") begin step_pos(c); mode = L_HEX; end
				else if (c == "b" || c == "B") begin step_pos(c); mode = L_BIN; end
				else num_int(c);
			end
			L_NUM_INT: num_int(c);
			L_NUM_DOT: begin
				if (c == ".") begin close_token(K_NUMBER); replay_held(c); end
				else begin take_held(); num_frac(c); end
			end
			L_NUM_FRAC: num_frac(c);
			L_NUM_E: begin
				if (c == "+" || c == "-") begin hold(c); mode = L_NUM_ES; end
				else if (is_dig(c)) begin take_held(); step_pos(c); mode = L_NUM_EXP; end
				else begin close_token(K_NUMBER); replay_held(c); end
			end
			L_NUM_ES: begin
				if (is_dig(c)) begin take_held(); step_pos(c); mode = L_NUM_EXP; end
				else begin close_token(K_NUMBER); replay_held(c); end
			end
			L_NUM_EXP, L_HEX_EXP: begin
				if (is_dig(c)) step_pos(c);
				else begin close_token(K_NUMBER); requeue(c); end
			end
			L_HEX: begin
				if (is_hexd(c) || c == ".") step_pos(c);
				else if (c == "p" || c == "P") begin step_pos(c); mode = L_HEX_P; end
				else begin close_token(K_NUMBER); requeue(c); end
			end
			L_HEX_P: begin
				if (c == "+" || c == "-" || is_dig(c)) begin step_pos(c); mode = L_HEX_EXP; end
				else begin close_token(K_NUMBER); requeue(c); end
			end
			L_BIN: begin
				if (c == "0" || c == "1") step_pos(c);
				else begin close_token(K_NUMBER); requeue(c); end
			end
			L_WORD: begin
				if (is_alpha(c) || is_dig(c)) step_pos(c);
				else begin close_token(K_WORD); requeue(c); end
			end
			default: begin mode = L_IDLE; requeue(c); end
		endcase
	endfunction

	function automatic void predict_tokens(bit act, bit [7:0] b);
		step_tokens.delete();
		lex_work.delete();
		lex_work.push_front(act ? END_CODE : int'(b));
		while (lex_work.size() > 0) lex_feed(lex_work.pop_front());
		if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1;
		foreach (step_tokens[i]) expected_tokens.insert(expected_tokens.size(), step_tokens[i]);
	endfunction

	// stimulus helpers
	function automatic void add_text(string s);
		src_item_t it;
		for (int i = 0; i < s.len(); i++) begin
			it.act = ACT_BYTE; it.b = s[i];
			source_q.insert(source_q.size(), it);
		end
	endfunction

	function automatic void add_byte(bit [7:0] b);
		src_item_t it;
		it.act = ACT_BYTE; it.b = b;
		source_q.insert(source_q.size(), it);
	endfunction

	function automatic void add_end();
		src_item_t it;
		it.act = ACT_END; it.b = 8'($urandom_range(0, 255));
		source_q.insert(source_q.size(), it);
	endfunction

	function automatic string pick(string s);
		string r;
		r = " ";
		r[0] = s[$urandom_range(0, s.len() - 1)];
		return r;
	endfunction

	function automatic string digits(string set, int n);
		string r;
		r = "";
		for (int i = 0; i < n; i++) r = {r, pick(set)};
		return r;
	endfunction

	function automatic string eq_run(int n);
		string r;
		r = "";
		for (int i = 0; i < n; i++) r = {r, "="};
		return r;
	endfunction

	function automatic string body_text(int n);
		string r;
		r = "";
		for (int i = 0; i < n; i++) r = {r, pick("ab ]=[\n\\\"'x9")};
		return r;
	endfunction

	function automatic void add_fragment();
		string s;
		int lv;
		case ($urandom_range(0, 13))
			0: s = {pick("abcXYZ_"), digits("abz_Q09", $urandom_range(0, 5))};
			1: s = digits("0123456789", $urandom_range(1, 4));
			2: s = {digits("0123456789", $urandom_range(1, 3)), pick(".eE"),
				pick("+-0123456789.ex"), digits("0123456789", $urandom_range(0, 2))};
			3: s = {"0", pick("xXbB"), digits("0189aFfp.+-", $urandom_range(0, 5))};
			4: s = {".", pick(".0123456789a"), pick(". 5e")};
			5: s = {pick("\"'"), body_text($urandom_range(0, 6)), pick("\"'")};
			6: begin
				lv = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 10) : $urandom_range(0, 2);
				s = {"[", eq_run(lv), "[", body_text($urandom_range(0, 6)), "]",
					eq_run($urandom_range(0, 1) ? lv : $urandom_range(0, 10)), "]"};
			end
			7: begin
				lv = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 10) : $urandom_range(0, 2);
				s = {"--", pick("[x"), eq_run(lv), pick("[ \n"), body_text($urandom_range(0, 5)),
					"]", eq_run(lv), "]\n"};
			end
			8: s = {pick("-:=~<>/.+*#%^&|(){};,"), pick(":=~<>/.-x ")};
			9: s = {"[", eq_run($urandom_range(0, 10)), pick("=[a ")};
			10: s = {pick(" \t\r\n"), pick(" \n")};
			11: begin
				add_byte(8'($urandom_range(0, 255)));
				return;
			end
			12: s = "...";
			default: begin
				if ($urandom_range(0, 3) == 0) begin
					add_end();
					return;
				end
				s = " ";
			end
		endcase
		add_text(s);
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		lexer_clear();
		add_text("a1=0x.Fp+2 3.5e-7 0b101 1..x 2ex\n");
		add_byte(8'h00);
		add_byte(8'hFF);
		add_text("'a\\'b'\"q");
		add_end();
		add_text("--[=[c]=] [==[s]==]");
		add_text("~=<<>>=//::==.. 1e+");
		add_end();
		while (source_q.size() < 450) add_fragment();
		add_text("x [[open");
		add_end();
		repeat (6) @(posedge clk);
		arst_n <= 1;
	end

	// input driver
	int  in_gap = 0;
	bit  in_quiet = 0;
	always @(posedge clk or negedge arst_n) begin
		src_item_t it;
		if (!arst_n) begin
			in_valid <= 0;
		end else begin
			if (in_valid && !in_stall) predict_tokens(action, src_byte);
			if ($urandom_range(0, 63) == 0) in_quiet = ~in_quiet;
			if (!in_valid || !in_stall) begin
				if (in_gap > 0) begin
					in_gap <= in_gap - 1;
					in_valid <= 0;
				end else if (source_q.size() > 0) begin
					it = source_q.pop_front();
					action <= it.act;
					src_byte <= it.b;
					in_valid <= 1;
					in_gap <= in_quiet ? 0 : gap_len();
				end else begin
					in_valid <= 0;
				end
			end
		end
	end

	// output monitor
	int  out_gap = 0;
	bit  out_quiet = 0;
	always @(posedge clk or negedge arst_n) begin
		token_t got, want;
		if (!arst_n) begin
			out_stall <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				got = {token_kind, start_line, start_column, start_offset, token_length,
					level_overflow, last_of_run};
				if (expected_tokens.size() == 0) begin
					errors++;
					$display("%0t unexpected token transfer: %h", $time, got);
				end else begin
					want = expected_tokens.pop_front();
					if (got.kind !== want.kind) begin
						errors++;
						$display("%0t token_kind exp %0d got %0d", $time, want.kind, got.kind);
					end
					if (got.line !== want.line) begin
						errors++;
						$display("%0t start_line exp %0d got %0d", $time, want.line, got.line);
					end
					if (got.col !== want.col) begin
						errors++;
						$display("%0t start_column exp %0d got %0d", $time, want.col, got.col);
					end
					if (got.off !== want.off) begin
						errors++;
						$display("%0t start_offset exp %0d got %0d", $time, want.off, got.off);
					end
					if (got.len !== want.len) begin
						errors++;
						$display("%0t token_length exp %0d got %0d", $time, want.len, got.len);
					end
					if (got.ovf !== want.ovf) begin
						errors++;
						$display("%0t level_overflow exp %0d got %0d", $time, want.ovf, got.ovf);
					end
					if (got.last !== want.last) begin
						errors++;
						$display("%0t last_of_run exp %0d got %0d", $time, want.last, got.last);
					end
				end
			end
			if ($urandom_range(0, 63) == 0) out_quiet = ~out_quiet;
			if (out_gap > 0) begin
				out_gap <= out_gap - 1;
				out_stall <= 1;
			end else begin
				out_stall <= 0;
				out_gap <= out_quiet ? 0 : gap_len();
			end
		end
	end

	initial begin
		@(posedge arst_n);
		while (source_q.size() > 0 || in_valid) @(posedge clk);
		while (expected_tokens.size() > 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (errors == 0 && expected_tokens.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#10000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

[filelist.f]
design/sstok_pkg.sv
design/sstok_ctrl.sv
design/sstok_dp.sv
design/script_source_tokenizer_top.sv
test/tb_script_source_tokenizer_top.sv
